>>> rtl/core/assert_macros.svh
// Assertion macros shared by the sorted list engine modules.
// Each use expects clk and rst (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define SDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sdl_pkg.sv
// Shared types and codes for the sorted descending list engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sdl_pkg;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_DEL_EQ    = 3'd1;
  localparam logic [2:0] OP_DEL_AFTER = 3'd2;
  localparam logic [2:0] OP_COUNT     = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         match_count;
    logic [6:0]         length;
    logic signed [31:0] read_value;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic ex;
    logic sh_rd;
    logic sh_ex;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk;
    logic fill_now;
    logic ex_end;
    logic need_shift;
    logic sh_end;
  } stat_t;

endpackage

>>> rtl/core/sdl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/sdl_ctrl.sv
// Controller of the sorted list engine: sequences load, walk, shift and publish.
// Depends on sdl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_busy,
  input  sdl_pkg::stat_t st,
  output logic          ready,
  output sdl_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_SH_RD = 6'b001000,
    S_SH_EX = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.walk ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = st.fill_now ? S_DONE : S_EXEC;
      end
      S_EXEC: begin
        cmd.ex = 1'b1;
        if (st.ex_end) begin
          state_next = st.need_shift ? S_SH_RD : S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_SH_RD: begin
        cmd.sh_rd  = 1'b1;
        state_next = S_SH_EX;
      end
      S_SH_EX: begin
        cmd.sh_ex  = 1'b1;
        state_next = st.sh_end ? S_DONE : S_SH_RD;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign ready = (state == S_IDLE);

  `SDL_ASSERT_NEXT(a_load_busy, cmd.load, !ready, "accepted beat did not occupy the engine")
  `SDL_ASSERT_NEXT(a_publish_idle, cmd.publish, ready, "engine not free after publishing")
  `SDL_ASSERT_NEXT(a_done_hold, (state == S_DONE) && out_busy, state == S_DONE,
                   "result left while output was blocked")

endmodule

>>> rtl/core/sdl_dpath.sv
// Datapath of the sorted list engine: entry RAM, count, walk pointers, result.
// Depends on sdl_pkg, sdl_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdl_dpath #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  sdl_pkg::in_item_t  item,
  input  sdl_pkg::cmd_t      cmd,
  output sdl_pkg::stat_t     st,
  output sdl_pkg::out_item_t result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);

  logic [2:0]                    op_r;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [5:0]                    idx_r;
  logic [CW-1:0]                 cnt, rp, wp, mcnt;
  logic                          skip;
  logic [1:0]                    status_r;
  logic signed [VALUE_WIDTH-1:0] rdval;

  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;
  logic signed [VALUE_WIDTH-1:0] wdata, rdata;

  logic signed [63:0]            in_wide, rd_wide;
  logic signed [VALUE_WIDTH-1:0] key_in;
  logic                          idx_over, ins_less, eq, keep, skip_new;
  logic [CW-1:0]                 rp_m1, rp_p1, wp_new;

  sdl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_wide  = 64'(item.value);
  assign key_in   = in_wide[VALUE_WIDTH-1:0];
  assign idx_over = (CW + 6)'(item.index) >= (CW + 6)'(cnt);
  assign ins_less = rdata < key;
  assign eq       = rdata == key;
  assign rp_m1    = rp - ONE;
  assign rp_p1    = rp + ONE;
  assign keep     = (op_r == sdl_pkg::OP_DEL_AFTER) ? !skip : !eq;
  assign skip_new = skip ? 1'b0 : eq;
  assign wp_new   = keep ? wp + ONE : wp;

  always_comb begin
    case (item.op) inside
      sdl_pkg::OP_INSERT: st.walk = cnt != FULL_CNT;
      sdl_pkg::OP_DEL_EQ, sdl_pkg::OP_DEL_AFTER, sdl_pkg::OP_COUNT: st.walk = cnt != '0;
      sdl_pkg::OP_READ: st.walk = (cnt != '0) && !idx_over;
      default: st.walk = 1'b0;
    endcase
    st.fill_now   = (op_r == sdl_pkg::OP_INSERT) && (rp == '0);
    case (op_r) inside
      sdl_pkg::OP_INSERT: st.ex_end = !ins_less;
      sdl_pkg::OP_DEL_EQ, sdl_pkg::OP_DEL_AFTER, sdl_pkg::OP_COUNT: st.ex_end = rp_p1 == cnt;
      default: st.ex_end = 1'b1;
    endcase
    st.need_shift = (op_r == sdl_pkg::OP_DEL_AFTER) && skip_new && (wp_new > ONE);
    st.sh_end     = rp == cnt;
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = rp[AW-1:0];
    raddr = rp[AW-1:0];
    wdata = key;
    if (cmd.rd) begin
      if (st.fill_now) begin
        we    = 1'b1;
        waddr = '0;
      end else begin
        re = 1'b1;
        if (op_r == sdl_pkg::OP_INSERT) begin
          raddr = rp_m1[AW-1:0];
        end else if (op_r == sdl_pkg::OP_READ) begin
          raddr = AW'(idx_r);
        end
      end
    end
    if (cmd.ex) begin
      case (op_r) inside
        sdl_pkg::OP_INSERT: begin
          // move smaller entries up one place, drop the key behind the first entry not smaller than it
          we    = 1'b1;
          wdata = ins_less ? rdata : key;
        end
        sdl_pkg::OP_DEL_EQ, sdl_pkg::OP_DEL_AFTER: begin
          we    = keep;
          waddr = wp[AW-1:0];
          wdata = rdata;
        end
        default: ;
      endcase
    end
    if (cmd.sh_rd) begin
      re = 1'b1;
    end
    if (cmd.sh_ex) begin
      we    = 1'b1;
      waddr = rp_m1[AW-1:0];
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      if (item.op == sdl_pkg::OP_CLEAR) begin
        cnt <= '0;
      end
    end else if (cmd.rd && st.fill_now) begin
      cnt <= cnt + ONE;
    end else if (cmd.ex) begin
      if (op_r == sdl_pkg::OP_INSERT && !ins_less) begin
        cnt <= cnt + ONE;
      end else if (st.ex_end && op_r == sdl_pkg::OP_DEL_EQ) begin
        cnt <= wp_new;
      end else if (st.ex_end && op_r == sdl_pkg::OP_DEL_AFTER) begin
        // successor of the last match is the head: drop it too
        cnt <= skip_new ? wp_new - ONE : wp_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= item.op;
      key      <= key_in;
      idx_r    <= item.index;
      rp       <= (item.op == sdl_pkg::OP_INSERT) ? cnt : '0;
      wp       <= '0;
      mcnt     <= (item.op == sdl_pkg::OP_CLEAR) ? cnt : '0;
      skip     <= 1'b0;
      rdval    <= '0;
      status_r <= sdl_pkg::ST_OK;
      case (item.op) inside
        sdl_pkg::OP_INSERT: begin
          if (cnt == FULL_CNT) status_r <= sdl_pkg::ST_FULL;
        end
        sdl_pkg::OP_DEL_EQ, sdl_pkg::OP_DEL_AFTER, sdl_pkg::OP_COUNT: begin
          if (cnt == '0) status_r <= sdl_pkg::ST_EMPTY;
        end
        sdl_pkg::OP_READ: begin
          if (cnt == '0) status_r <= sdl_pkg::ST_EMPTY;
          else if (idx_over) status_r <= sdl_pkg::ST_RANGE;
        end
        default: ;
      endcase
    end else if (cmd.ex) begin
      case (op_r)
        sdl_pkg::OP_INSERT: begin
          if (ins_less) rp <= rp_m1;
        end
        sdl_pkg::OP_DEL_EQ: begin
          rp <= rp_p1;
          wp <= wp_new;
          if (eq) mcnt <= mcnt + ONE;
        end
        sdl_pkg::OP_DEL_AFTER: begin
          rp   <= (st.ex_end && skip_new) ? ONE : rp_p1;
          wp   <= wp_new;
          skip <= skip_new;
          if (!skip && eq) mcnt <= mcnt + ONE;
        end
        sdl_pkg::OP_COUNT: begin
          rp <= rp_p1;
          if (eq) mcnt <= mcnt + ONE;
        end
        sdl_pkg::OP_READ: rdval <= rdata;
        default: ;
      endcase
    end else if (cmd.sh_ex) begin
      rp <= rp_p1;
    end
  end

  assign rd_wide = 64'(rdval);

  always_comb begin
    result.status      = status_r;
    result.match_count = 7'(mcnt);
    result.length      = 7'(cnt);
    result.read_value  = rd_wide[31:0];
  end

  `SDL_ASSERT(a_cnt_bound, cnt <= FULL_CNT, "entry count above depth")
  `SDL_ASSERT(a_compact_order,
              cmd.ex && (op_r == sdl_pkg::OP_DEL_EQ || op_r == sdl_pkg::OP_DEL_AFTER)
              |-> wp <= rp, "compaction write pointer passed read pointer")
  `SDL_ASSERT(a_shift_range, cmd.sh_ex |-> (rp != '0) && (rp <= cnt),
              "head removal shift out of range")

endmodule

>>> rtl/core/sorted_descending_list_engine_unit.sv
// Sorted descending list engine: up to DEPTH signed words kept largest first.
// Channels: in_item (op, value, index) and out_item (status, match_count,
// length, read_value), each with valid and stall; a beat moves when valid is
// high and stall is low. Every accepted beat returns exactly one result beat.
// One operation is worked at a time; a new beat is taken while the previous
// result still sits in the output register.
// Clear, unused ops, full insert, empty table and read out of range skip the
// walk. Read visits the one indexed entry; count and both deletes visit every
// entry; insert visits the entries it moves up plus the one it stops at
// (if any). Delete after adds a shift pass over the kept entries when the head
// is removed.
// The walk is set by the single entry RAM: one read and at most one write per
// entry, with a registered read port.
// Reset empties the table by zeroing its count (no clearing pass) and drops
// any pending result. While out_stall is high the result holds; the engine
// finishes its current op and waits, then holds in_stall high.
`timescale 1ns / 1ps

module sorted_descending_list_engine_unit #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sdl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sdl_pkg::out_item_t out_item
);

  sdl_pkg::cmd_t      cmd;
  sdl_pkg::stat_t     st;
  sdl_pkg::out_item_t result;
  logic               ready;

  sdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_valid && out_stall),
    .st       (st),
    .ready    (ready),
    .cmd      (cmd)
  );

  sdl_dpath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (in_item),
    .cmd    (cmd),
    .st     (st),
    .result (result)
  );

  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_item <= result;
    end
  end

endmodule
